FILE: src/battery_avg_outlier_reject_assert.svh
// Assertion macros shared by the battery averager RTL.
`ifndef BATTERY_AVG_OUTLIER_REJECT_ASSERT_SVH
`define BATTERY_AVG_OUTLIER_REJECT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define BAVG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define BAVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bavg_pkg.sv
// Shared widths, constants and codes of the battery averager.
package bavg_pkg;

  localparam int ADC_W = 12;
  localparam int MV_W = 13;
  localparam int LEVEL_W = 2;
  localparam int KEPT_W = 4;
  localparam int TOL_W = 12;

  localparam int SCALE_NUM = 4587;
  localparam int SCALE_SHIFT = 12;
  localparam int PROD_W = ADC_W + MV_W;
  localparam int MV_MAX = 4586;

  localparam int ROUNDS_DEF = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINIMUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW = 2'd2;

  localparam logic [TOL_W-1:0] TOL_RESET = 12'd100;
  localparam logic [MV_W-1:0] MINIMUM_RESET = 13'd3400;
  localparam logic [MV_W-1:0] LOW_RESET = 13'd3600;

  localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_SHUTDOWN = 2'd2;

endpackage

FILE: src/bavg_ifs.sv
// Input and result stream interfaces of the battery averager.
interface bavg_in_if import bavg_pkg::*; ();
  logic valid;
  logic ready;
  logic [ADC_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface bavg_out_if import bavg_pkg::*; ();
  logic valid;
  logic ready;
  logic [MV_W-1:0] voltage_mv;
  logic [LEVEL_W-1:0] level;
  logic round_done;
  logic [KEPT_W-1:0] kept_samples;

  modport source (output valid, output voltage_mv, output level, output round_done,
                  output kept_samples, input ready);
  modport sink (input valid, input voltage_mv, input level, input round_done,
                input kept_samples, output ready);
endinterface

FILE: src/bavg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bavg_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bavg_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bavg_div #(
  parameter int DIVD_W = 17,
  parameter int DIVS_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int STEP_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign trial = {rem, quo[DIVD_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], ge};
      rem <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end
  end

endmodule

FILE: src/battery_avg_outlier_reject.sv
// Battery averager top level: sample store, round sequencer and result register.
// One sample is in work at a time. A sample that does not end a round passes the scale,
// update and output states, and the next is taken once its result is in the output register.
// A round-ending sample also runs the one-bit-per-cycle divider over SUM_W bits, reads the
// stored samples and reruns it for each rejection that leaves samples (SUM_W is 16 here).
// Reset is synchronous: sum, count and filtered voltage clear, registers take defaults.
module battery_avg_outlier_reject import bavg_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bavg_in_if.sink               sample,
  bavg_out_if.source            result,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "battery_avg_outlier_reject_assert.svh"

  localparam int ADDR_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int CNT_W = $clog2(ROUNDS + 1);
  localparam int SUM_W = $clog2(ROUNDS * MV_MAX + 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCALE  = 9'b000000010,
    ST_UPDATE = 9'b000000100,
    ST_DSTART = 9'b000001000,
    ST_DWAIT  = 9'b000010000,
    ST_READ   = 9'b000100000,
    ST_CHECK  = 9'b001000000,
    ST_FINISH = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [TOL_W-1:0] tolerance;
  logic [MV_W-1:0]  minimum;
  logic [MV_W-1:0]  low;

  logic [ADC_W-1:0]  code_q;
  logic [MV_W-1:0]   mv_q;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  wsum;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  remain;
  logic [CNT_W-1:0]  remain_next;
  logic [CNT_W-1:0]  idx;
  logic [MV_W-1:0]   avg;
  logic [MV_W-1:0]   filtered;
  logic              done_q;
  logic [KEPT_W-1:0] kept_q;

  logic [MV_W-1:0]  rd_data;
  logic [MV_W-1:0]  dev;
  logic             drop;
  logic             idx_last;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic             out_load;

  logic              out_valid;
  logic [MV_W-1:0]   out_voltage;
  logic [LEVEL_W-1:0] out_level;
  logic              out_done;
  logic [KEPT_W-1:0] out_kept;
  logic [LEVEL_W-1:0] level_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      minimum <= MINIMUM_RESET;
      low <= LOW_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        REG_MINIMUM:   minimum <= cfg_data[MV_W-1:0];
        REG_LOW:       low <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  bavg_ram #(
    .WIDTH(MV_W),
    .DEPTH(ROUNDS)
  ) u_store (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (count[ADDR_W-1:0]),
    .wdata (mv_q),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  bavg_div #(
    .DIVD_W(SUM_W),
    .DIVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DSTART),
    .dividend (wsum),
    .divisor  (remain),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign prod = PROD_W'(code_q) * PROD_W'(SCALE_NUM);
  assign sum_next = sum + SUM_W'(mv_q);
  assign dev = (rd_data > avg) ? (rd_data - avg) : (avg - rd_data);
  assign drop = dev > MV_W'(tolerance);
  assign remain_next = remain - 1'b1;
  assign idx_last = idx == CNT_W'(ROUNDS - 1);
  assign out_load = (state == ST_OUT) && (!out_valid || result.ready);

  always_comb begin
    priority if (filtered < minimum) begin
      level_now = LEVEL_SHUTDOWN;
    end else if (filtered < low) begin
      level_now = LEVEL_LOW;
    end else begin
      level_now = LEVEL_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sum <= '0;
      count <= '0;
      filtered <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_UPDATE;
        ST_UPDATE: begin
          if (count + 1'b1 == CNT_W'(ROUNDS)) begin
            sum <= '0;
            count <= '0;
            state <= ST_DSTART;
          end else begin
            sum <= sum_next;
            count <= count + 1'b1;
            state <= ST_OUT;
          end
        end
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            state <= (idx == CNT_W'(ROUNDS)) ? ST_FINISH : ST_READ;
          end
        end
        ST_READ: state <= ST_CHECK;
        ST_CHECK: begin
          priority if (drop && remain_next != '0) begin
            state <= ST_DSTART;
          end else if (idx_last) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_READ;
          end
        end
        ST_FINISH: begin
          if (remain != '0) begin
            filtered <= avg;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample.valid) begin
      code_q <= sample.adc_code;
    end
    if (state == ST_SCALE) begin
      mv_q <= prod[PROD_W-1:SCALE_SHIFT];
    end
    if (state == ST_UPDATE) begin
      wsum <= sum_next;
      remain <= CNT_W'(ROUNDS);
      idx <= '0;
      done_q <= 1'b0;
      kept_q <= '0;
    end
    if (state == ST_DWAIT && div_done) begin
      avg <= div_quo[MV_W-1:0];
    end
    if (state == ST_CHECK) begin
      idx <= idx + 1'b1;
      if (drop) begin
        wsum <= wsum - SUM_W'(rd_data);
        remain <= remain_next;
      end
    end
    if (state == ST_FINISH) begin
      done_q <= 1'b1;
      kept_q <= KEPT_W'(remain);
    end
    if (out_load) begin
      out_voltage <= filtered;
      out_level <= level_now;
      out_done <= done_q;
      out_kept <= kept_q;
    end
  end

  assign sample.ready = state == ST_IDLE;
  assign result.valid = out_valid;
  assign result.voltage_mv = out_voltage;
  assign result.level = out_level;
  assign result.round_done = out_done;
  assign result.kept_samples = out_kept;

  `BAVG_ASSERT_NOW(a_count_in_range, state == ST_IDLE, count < CNT_W'(ROUNDS), "sample count reached the round length while idle")
  `BAVG_ASSERT_NOW(a_kept_only_on_round, result.valid && !result.round_done, result.kept_samples == '0, "kept count reported without a completed round")
  `BAVG_ASSERT_NOW(a_kept_bounded, result.valid, result.kept_samples <= KEPT_W'(ROUNDS), "more samples kept than a round holds")
  `BAVG_ASSERT_NEXT(a_one_item_at_a_time, sample.valid && sample.ready, !sample.ready, "a second sample was taken while one is in work")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the battery voltage averager with outlier rejection.
module testbench import bavg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int ADC_MAX = 4095;
  localparam int PHASE_ITEMS = 108;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [MV_W-1:0] voltage_mv;
    logic [LEVEL_W-1:0] level;
    logic round_done;
    logic [KEPT_W-1:0] kept_samples;
  } battery_result_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_RARE_STALL
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bavg_in_if sample_ch ();
  bavg_out_if result_ch ();

  battery_avg_outlier_reject dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [TOL_W-1:0] tolerance_mv;
  logic [MV_W-1:0] shutdown_mv;
  logic [MV_W-1:0] low_limit_mv;
  logic [MV_W-1:0] round_mv [ROUNDS_DEF];
  int unsigned round_sum_mv;
  int unsigned round_fill;
  logic [MV_W-1:0] filtered_mv;

  battery_result_t expected_battery_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int sent_total = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic battery_result_t predict_battery_result(input logic [ADC_W-1:0] code);
    battery_result_t res;
    int unsigned mv;
    int unsigned sum;
    int unsigned remain;
    int unsigned avg;
    int unsigned s;
    int unsigned dev;
    res = '0;
    mv = (32'(code) * SCALE_NUM) >> SCALE_SHIFT;
    round_mv[round_fill] = mv[MV_W-1:0];
    round_sum_mv += mv;
    round_fill++;
    if (round_fill >= ROUNDS_DEF) begin
      remain = round_fill;
      sum = round_sum_mv;
      avg = sum / remain;
      for (int i = 0; i < ROUNDS_DEF; i++) begin
        s = 32'(round_mv[i]);
        dev = (s > avg) ? s - avg : avg - s;
        if (dev > 32'(tolerance_mv)) begin
          sum -= s;
          remain--;
          if (remain > 0) avg = sum / remain;
        end
      end
      if (remain > 0) filtered_mv = avg[MV_W-1:0];
      res.round_done = 1'b1;
      res.kept_samples = remain[KEPT_W-1:0];
      round_fill = 0;
      round_sum_mv = 0;
    end
    res.voltage_mv = filtered_mv;
    if (filtered_mv < shutdown_mv) res.level = LEVEL_SHUTDOWN;
    else if (filtered_mv < low_limit_mv) res.level = LEVEL_LOW;
    else res.level = LEVEL_NORMAL;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    battery_result_t want;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        expected_battery_results.push_back(predict_battery_result(sample_ch.adc_code));
      if (result_ch.valid && result_ch.ready) begin
        if (expected_battery_results.size() == 0) begin
          $display("%0t unexpected beat: voltage_mv %0d level %0d round_done %0d kept %0d",
                   $time, result_ch.voltage_mv, result_ch.level, result_ch.round_done,
                   result_ch.kept_samples);
          mismatches++;
        end else begin
          want = expected_battery_results.pop_front();
          check_field("voltage_mv", 32'(want.voltage_mv), 32'(result_ch.voltage_mv));
          check_field("level", 32'(want.level), 32'(result_ch.level));
          check_field("round_done", 32'(want.round_done), 32'(result_ch.round_done));
          check_field("kept_samples", 32'(want.kept_samples), 32'(result_ch.kept_samples));
        end
      end
    end
  end

  initial begin : result_receiver
    rx_mode_t mode;
    int segment_left;
    int hold_left;
    int phase;
    mode = RX_ALWAYS;
    segment_left = 0;
    hold_left = 0;
    phase = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (segment_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        segment_left = $urandom_range(20, 200);
      end
      segment_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: result_ch.ready = 1'b1;
          RX_RANDOM: result_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: result_ch.ready = (phase % 4 == 0);
          default: result_ch.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_sample(input logic [ADC_W-1:0] code);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        sample_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sample_ch.valid = 1'b1;
    sample_ch.adc_code = code;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sent_total++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (expected_battery_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wen = 1'b0;
    case (idx)
      REG_TOLERANCE: tolerance_mv = data[TOL_W-1:0];
      REG_MINIMUM: shutdown_mv = data;
      REG_LOW: low_limit_mv = data;
      default: ;
    endcase
  endtask

  // Completes the round in progress with samples clustered around a random base.
  task automatic send_cluster(output int count);
    int base;
    int spread;
    int code;
    base = $urandom_range(0, ADC_MAX);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 8;
      2: spread = 90;
      default: spread = 400;
    endcase
    count = ROUNDS_DEF - (sent_total % ROUNDS_DEF);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) code = $urandom_range(0, ADC_MAX);
      else code = base + $urandom_range(0, 2 * spread) - spread;
      if (code < 0) code = 0;
      if (code > ADC_MAX) code = ADC_MAX;
      send_sample(code[ADC_W-1:0]);
    end
  endtask

  task automatic test_scaling_extremes();
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd1);
    send_sample(12'hFFE);
    send_sample(12'h800);
    send_sample(12'h7FF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    wait_idle();
  endtask

  task automatic test_uniform_round();
    // The round lands exactly on the minimum, which must read as low.
    write_reg(REG_MINIMUM, 13'd3415);
    write_reg(REG_LOW, 13'd3416);
    repeat (ROUNDS_DEF) send_sample(12'd3050);
    wait_idle();
  endtask

  task automatic test_tolerance_zero();
    // Bit 12 is outside the tolerance register, so this write leaves it at zero.
    write_reg(REG_TOLERANCE, 13'h1000);
    write_reg(REG_UNUSED, 13'h0055);
    repeat (ROUNDS_DEF - 1) send_sample(12'd2000);
    send_sample(12'hFFF);
    wait_idle();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (48) send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_rounds();
    int sent;
    int count;
    int lo;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      case (phase % 6)
        0: begin
          write_reg(REG_TOLERANCE, 13'd0);
          write_reg(REG_MINIMUM, 13'd0);
          write_reg(REG_LOW, 13'd0);
        end
        1: begin
          write_reg(REG_TOLERANCE, 13'h1FFF);
          write_reg(REG_MINIMUM, CFG_DATA_W'(MV_MAX));
          write_reg(REG_LOW, CFG_DATA_W'(MV_MAX));
        end
        2: begin
          write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 200)));
          write_reg(REG_MINIMUM, 13'h1FFF);
          write_reg(REG_LOW, 13'h1FFF);
        end
        3: begin
          lo = $urandom_range(2500, 3600);
          write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 400)));
          write_reg(REG_MINIMUM, CFG_DATA_W'(lo));
          write_reg(REG_LOW, CFG_DATA_W'($urandom_range(lo, MV_MAX)));
        end
        4: begin
          write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
          write_reg(REG_MINIMUM, CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
          write_reg(REG_LOW, CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
        end
        default: begin
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 13'h1FFF)));
          write_reg(REG_TOLERANCE, CFG_DATA_W'(TOL_RESET));
          write_reg(REG_MINIMUM, MINIMUM_RESET);
          write_reg(REG_LOW, LOW_RESET);
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          send_cluster(count);
          sent += count;
        end else begin
          count = $urandom_range(1, 5);
          repeat (count) send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
          sent += count;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = REG_TOLERANCE;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.adc_code = '0;
    tolerance_mv = TOL_RESET;
    shutdown_mv = MINIMUM_RESET;
    low_limit_mv = LOW_RESET;
    round_sum_mv = 0;
    round_fill = 0;
    filtered_mv = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_scaling_extremes();
    test_uniform_round();
    test_tolerance_zero();
    test_backpressure();
    test_random_rounds();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_battery_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
